@@ design/srdc_pkg.sv @@
`timescale 1ns / 1ps

package srdc_pkg;

  // APB address width: four 32-bit registers at byte offsets 0, 4, 8, 12
  localparam int APB_AW = 4;

  localparam int N_LINES = 6;

  localparam logic [16:0] UNITY     = 17'd32768;
  localparam logic [14:0] DECAY_MAX = 15'd32112;

  typedef enum logic [1:0] {
    REG_WET_MIX      = 2'd0,
    REG_DECAY        = 2'd1,
    REG_DAMPING      = 2'd2,
    REG_PREDELAY_LEN = 2'd3
  } reg_e;

  // delay lines held in the shared delay memory
  typedef enum logic [2:0] {
    LN_COMB_A = 3'd0,
    LN_COMB_B = 3'd1,
    LN_COMB_C = 3'd2,
    LN_COMB_D = 3'd3,
    LN_AP_A   = 3'd4,
    LN_AP_B   = 3'd5
  } line_e;

  typedef struct packed {
    logic [15:0] wet_mix;
    logic [14:0] decay_gain;
    logic [15:0] damping;
    logic [12:0] predelay_len;
    logic        pd_clear;     // one-cycle pulse on any predelay_len write
  } cfg_t;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -48'sd8388608) begin
      return 24'sh800000;
    end
    return 24'(v);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -48'sd32768) begin
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

endpackage

@@ design/srdc_stream_if.sv @@
`timescale 1ns / 1ps

interface srdc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

interface srdc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

@@ design/srdc_regs.sv @@
`timescale 1ns / 1ps

module srdc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srdc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output srdc_pkg::cfg_t              cfg_o
);

  logic [15:0] wet_q;
  logic [14:0] decay_q;
  logic [15:0] damp_q;
  logic [12:0] plen_q;
  logic        wr;
  srdc_pkg::reg_e idx;

  assign idx = srdc_pkg::reg_e'(paddr[srdc_pkg::APB_AW-1:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wet_q   <= 16'd16384;
      decay_q <= 15'd16384;
      damp_q  <= 16'd16384;
      plen_q  <= 13'd1;
    end else if (wr) begin
      case (idx)
        srdc_pkg::REG_WET_MIX:      wet_q   <= pwdata[15:0];
        srdc_pkg::REG_DECAY:        decay_q <= pwdata[14:0];
        srdc_pkg::REG_DAMPING:      damp_q  <= pwdata[15:0];
        srdc_pkg::REG_PREDELAY_LEN: plen_q  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      srdc_pkg::REG_WET_MIX:      prdata = {16'd0, wet_q};
      srdc_pkg::REG_DECAY:        prdata = {17'd0, decay_q};
      srdc_pkg::REG_DAMPING:      prdata = {16'd0, damp_q};
      srdc_pkg::REG_PREDELAY_LEN: prdata = {19'd0, plen_q};
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o.wet_mix      = wet_q;
  assign cfg_o.decay_gain   = decay_q;
  assign cfg_o.damping      = damp_q;
  assign cfg_o.predelay_len = plen_q;
  assign cfg_o.pd_clear     = wr && (idx == srdc_pkg::REG_PREDELAY_LEN);

endmodule

@@ design/srdc_pdline.sv @@
`timescale 1ns / 1ps

module srdc_pdline #(
  parameter int DEPTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srdc_pkg::cfg_t     cfg_i,
  input  logic               we_i,
  input  logic signed [15:0] wdata_i,
  output logic signed [15:0] rdata_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = AW + 1;

  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rd_q;
  logic [AW-1:0]      pos_q;
  logic               full_q;   // line has wrapped once: every entry written
  logic               hit_q;
  logic [LW-1:0]      plen;
  logic [LW-1:0]      nxt;
  logic               wrap;

  // effective length: zero acts as one, clamp to the store depth
  always_comb begin
    if (cfg_i.predelay_len == '0) begin
      plen = LW'(1);
    end else if (32'(cfg_i.predelay_len) > 32'(DEPTH)) begin
      plen = LW'(DEPTH);
    end else begin
      plen = LW'(cfg_i.predelay_len);
    end
  end

  assign nxt  = {1'b0, pos_q} + LW'(1);
  assign wrap = (nxt >= plen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      full_q <= 1'b0;
      hit_q  <= 1'b0;
    end else if (cfg_i.pd_clear) begin
      pos_q  <= '0;
      full_q <= 1'b0;
    end else if (we_i) begin
      hit_q <= full_q;
      if (wrap) begin
        pos_q  <= '0;
        full_q <= 1'b1;
      end else begin
        pos_q <= nxt[AW-1:0];
      end
    end
  end

  // read-before-write at the same position
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[pos_q] <= wdata_i;
      rd_q       <= mem[pos_q];
    end
  end

  assign rdata_o = hit_q ? rd_q : '0;

endmodule

@@ design/srdc_dline.sv @@
`timescale 1ns / 1ps

module srdc_dline #(
  parameter int RATE_HZ = 48000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srdc_pkg::line_e    rd_line_i,
  input  logic               we_i,
  input  srdc_pkg::line_e    wr_line_i,
  input  logic signed [23:0] wdata_i,
  output logic signed [23:0] rdata_o
);

  // line lengths: round(t * RATE_HZ)
  localparam int unsigned LEN [srdc_pkg::N_LINES] = '{
    (297 * RATE_HZ + 5000) / 10000,
    (371 * RATE_HZ + 5000) / 10000,
    (411 * RATE_HZ + 5000) / 10000,
    (437 * RATE_HZ + 5000) / 10000,
    (50 * RATE_HZ + 5000) / 10000,
    (17 * RATE_HZ + 5000) / 10000
  };
  localparam int unsigned BASE [srdc_pkg::N_LINES] = '{
    0,
    LEN[0],
    LEN[0] + LEN[1],
    LEN[0] + LEN[1] + LEN[2],
    LEN[0] + LEN[1] + LEN[2] + LEN[3],
    LEN[0] + LEN[1] + LEN[2] + LEN[3] + LEN[4]
  };
  localparam int unsigned TOTAL = BASE[5] + LEN[5];
  localparam int AW = $clog2(TOTAL);
  localparam int PW = $clog2(LEN[3]);

  logic signed [23:0] mem [TOTAL];
  logic signed [23:0] rd_q;
  logic               hit_q;
  logic [PW-1:0]      pos_q  [srdc_pkg::N_LINES];
  logic               wrap_q [srdc_pkg::N_LINES];
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               rd_full;

  always_comb begin
    raddr   = '0;
    waddr   = '0;
    rd_full = 1'b0;
    for (int i = 0; i < srdc_pkg::N_LINES; i++) begin
      if (rd_line_i == srdc_pkg::line_e'(3'(i))) begin
        raddr   = AW'(BASE[i]) + AW'(pos_q[i]);
        rd_full = wrap_q[i];
      end
      if (wr_line_i == srdc_pkg::line_e'(3'(i))) begin
        waddr = AW'(BASE[i]) + AW'(pos_q[i]);
      end
    end
  end

  // positions advance on write-back; wrap mark means every entry written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      for (int i = 0; i < srdc_pkg::N_LINES; i++) begin
        pos_q[i]  <= '0;
        wrap_q[i] <= 1'b0;
      end
    end else begin
      hit_q <= rd_full;
      for (int i = 0; i < srdc_pkg::N_LINES; i++) begin
        if (we_i && wr_line_i == srdc_pkg::line_e'(3'(i))) begin
          if (32'(pos_q[i]) + 32'd1 >= LEN[i]) begin
            pos_q[i]  <= '0;
            wrap_q[i] <= 1'b1;
          end else begin
            pos_q[i] <= pos_q[i] + PW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr] <= wdata_i;
    end
    rd_q <= mem[raddr];
  end

  assign rdata_o = hit_q ? rd_q : '0;

endmodule

@@ design/schroeder_reverb_damped_comb.sv @@
`timescale 1ns / 1ps
// Channel    Dir  Handshake                 Payload
// in_i       in   valid/ready               in_sample  (16b signed, Q1.15)
// out_o      out  valid/ready               out_sample (16b signed, Q1.15)
// APB        in   psel/penable/pwrite       paddr[3:0], pwdata/prdata 32b, pready = 1
//
// One request at a time: accept, 12 sequencer steps, result load.
// The step count is set by the delay memory's single write port (four comb
// and two allpass write-backs) behind the two multiply stages of each comb.
// Reset (async, active low) loads register defaults and clears line positions
// and fill marks; unwritten delay entries read as zero, so there is no sweep.
// A result waiting in the output register stalls only the final load; the
// next request is taken as soon as the result is loaded.

module schroeder_reverb_damped_comb #(
  parameter int RATE_HZ        = 48000,
  parameter int PREDELAY_DEPTH = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  srdc_in_if.sink                     in_i,
  srdc_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srdc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  localparam logic [3:0] T_AP_A_WR = 4'd9;
  localparam logic [3:0] T_AP_B_WR = 4'd10;
  localparam logic [3:0] T_LAST    = 4'd11;

  srdc_pkg::cfg_t cfg;
  state_e         state_q, state_d;
  logic [3:0]     t_q, t_d;

  logic [16:0] wet, dry, damp;
  logic [14:0] decay;

  logic in_acc, out_free, run;
  logic s1, s2, s3, s4;
  logic [1:0] k1, k3, k5;

  logic signed [15:0] x_q, pre_q, pd_rdata;
  logic signed [23:0] dl_rdata, dl_wdata;
  srdc_pkg::line_e    rd_line, wr_line;
  logic               dl_we;

  logic signed [23:0] lp_q [4];
  logic signed [23:0] lp_sel, lp1_q, lp2_q, lpn, lpn_q;
  logic signed [24:0] diff_q;
  logic signed [42:0] prod1_q, r1;
  logic signed [39:0] prod2_q, r2;
  logic signed [25:0] sum_q;
  logic signed [23:0] rev_q, ap_a_q, ap_b_q, ap_sel, ap_wr, ap_y, comb_wr;
  logic signed [24:0] half_ap, half_rev;
  logic signed [33:0] pdry_q;
  logic signed [41:0] pwet_q;
  logic signed [43:0] mix;
  logic               out_valid_q;
  logic signed [15:0] out_sample_q;

  srdc_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg_o  (cfg)
  );

  assign pready = 1'b1;

  // gain clamps: wet/damping at unity, decay at 0.98
  assign wet   = (cfg.wet_mix > 16'd32768) ? srdc_pkg::UNITY : {1'b0, cfg.wet_mix};
  assign dry   = srdc_pkg::UNITY - wet;
  assign damp  = (cfg.damping > 16'd32768) ? srdc_pkg::UNITY : {1'b0, cfg.damping};
  assign decay = (cfg.decay_gain > srdc_pkg::DECAY_MAX) ? srdc_pkg::DECAY_MAX
                                                       : cfg.decay_gain;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Pre-delay: read old sample and write the new one at the accept edge.
  srdc_pdline #(.DEPTH(PREDELAY_DEPTH)) u_pdline (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .we_i   (in_acc),
    .wdata_i(in_i.in_sample),
    .rdata_o(pd_rdata)
  );

  srdc_dline #(.RATE_HZ(RATE_HZ)) u_dline (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_line_i(rd_line),
    .we_i     (dl_we),
    .wr_line_i(wr_line),
    .wdata_i  (dl_wdata),
    .rdata_o  (dl_rdata)
  );

  // Step schedule (t):
  //   0-3  comb reads         1-4  delayed tap, diff vs. lowpass, comb sum
  //   2-5  diff * damping     3-6  lowpass update
  //   4-7  lowpass * decay    5-8  comb write-back
  //   4,5  allpass reads      5    rev = sum/4
  //   9,10 allpass update and write-back
  //   11   dry/wet products, then the result load in ST_DONE
  assign run = (state_q == ST_RUN);
  assign s1  = run && (t_q inside {[4'd1:4'd4]});
  assign s2  = run && (t_q inside {[4'd2:4'd5]});
  assign s3  = run && (t_q inside {[4'd3:4'd6]});
  assign s4  = run && (t_q inside {[4'd4:4'd7]});
  assign k1  = 2'(t_q - 4'd1);
  assign k3  = 2'(t_q - 4'd3);
  assign k5  = 2'(t_q - 4'd5);

  always_comb begin
    case (t_q) inside
      [4'd0:4'd3]: rd_line = srdc_pkg::line_e'({1'b0, t_q[1:0]});
      4'd4:        rd_line = srdc_pkg::LN_AP_A;
      default:     rd_line = srdc_pkg::LN_AP_B;
    endcase
  end

  // lowpass: lp += round((delayed - lp) * damp)
  assign lp_sel = lp_q[k1];
  assign r1     = (prod1_q + 43'sd16384) >>> 15;
  assign lpn    = srdc_pkg::sat24(48'(lp2_q) + 48'(r1));

  // comb feedback: pre + round(lp * decay)
  assign r2      = (prod2_q + 40'sd16384) >>> 15;
  assign comb_wr = srdc_pkg::sat24(48'(pre_q) + 48'(r2));

  // allpass with gain 1/2: round(v/2) = (v + 1) >>> 1
  assign ap_sel   = (t_q == T_AP_A_WR) ? ap_a_q : ap_b_q;
  assign half_ap  = (25'(ap_sel) + 25'sd1) >>> 1;
  assign half_rev = (25'(rev_q) + 25'sd1) >>> 1;
  assign ap_wr    = srdc_pkg::sat24(48'(rev_q) + 48'(half_ap));
  assign ap_y     = srdc_pkg::sat24(48'(ap_sel) - 48'(half_rev));

  assign dl_we = run && (t_q inside {[4'd5:T_AP_B_WR]});

  always_comb begin
    case (t_q) inside
      [4'd5:4'd8]: begin
        wr_line  = srdc_pkg::line_e'({1'b0, k5});
        dl_wdata = comb_wr;
      end
      T_AP_A_WR: begin
        wr_line  = srdc_pkg::LN_AP_A;
        dl_wdata = ap_wr;
      end
      default: begin
        wr_line  = srdc_pkg::LN_AP_B;
        dl_wdata = ap_wr;
      end
    endcase
  end

  assign mix = (44'(pdry_q) + 44'(pwet_q) + 44'sd16384) >>> 15;

  // sequencer
  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RUN;
          t_d     = '0;
        end
      end
      ST_RUN: begin
        if (t_q == T_LAST) begin
          state_d = ST_DONE;
        end else begin
          t_d = t_q + 4'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      t_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        lp_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      if (s3) begin
        lp_q[k3] <= lpn;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_i.in_sample;
    end
    if (run && t_q == 4'd0) begin
      pre_q <= pd_rdata;
    end
    if (s1) begin
      sum_q  <= ((t_q == 4'd1) ? 26'sd0 : sum_q) + 26'(dl_rdata);
      diff_q <= 25'(dl_rdata) - 25'(lp_sel);
      lp1_q  <= lp_sel;
    end
    if (s2) begin
      prod1_q <= diff_q * $signed({1'b0, damp});
      lp2_q   <= lp1_q;
    end
    if (s3) begin
      lpn_q <= lpn;
    end
    if (s4) begin
      prod2_q <= lpn_q * $signed({1'b0, decay});
    end
    if (run && t_q == 4'd5) begin
      ap_a_q <= dl_rdata;
      rev_q  <= srdc_pkg::sat24(48'((sum_q + 26'sd2) >>> 2));
    end
    if (run && t_q == 4'd6) begin
      ap_b_q <= dl_rdata;
    end
    if (run && (t_q == T_AP_A_WR || t_q == T_AP_B_WR)) begin
      rev_q <= ap_y;
    end
    if (run && t_q == T_LAST) begin
      pdry_q <= x_q * $signed({1'b0, dry});
      pwet_q <= rev_q * $signed({1'b0, wet});
    end
    if (state_q == ST_DONE && out_free) begin
      out_sample_q <= srdc_pkg::sat16(48'(mix));
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_sample = out_sample_q;

  a_accept_starts_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RUN) && (t_q == 4'd0))
    else $error("accepted request did not start the sequencer");

  a_step_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (t_q <= T_LAST))
    else $error("sequencer step past the last step");

  a_done_delivers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> out_o.valid && (state_q == ST_IDLE))
    else $error("finished result not presented");

  a_no_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN) |-> !dl_we && !in_acc || (state_q == ST_IDLE))
    else $error("delay memory written outside a run");

endmodule

@@ test/schroeder_reverb_damped_comb_test.sv @@
`timescale 1ns / 1ps

module schroeder_reverb_damped_comb_test;

  localparam int RATE        = 48000;
  localparam int PRE_DEPTH   = 4096;
  localparam int COMB_MAX    = (437 * RATE + 5000) / 10000;
  localparam int AP_MAX      = (50 * RATE + 5000) / 10000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_MAX  = 10;

  logic clk_i;
  logic rst_ni;

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [srdc_pkg::APB_AW-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  srdc_in_if  in_if ();
  srdc_out_if out_if ();

  schroeder_reverb_damped_comb #(
    .RATE_HZ        (RATE),
    .PREDELAY_DEPTH (PRE_DEPTH)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register shadow mirrored from writes, reverb state from accepted requests
  srdc_pkg::cfg_t shadow;
  int   pre_mem  [PRE_DEPTH];
  int   comb_mem [4][COMB_MAX];
  int   comb_lp  [4];
  int   ap_mem   [2][AP_MAX];
  int   pre_pos;
  int   comb_pos [4];
  int   ap_pos   [2];

  logic signed [15:0] due_samples [$];

  int fail_count;
  int samples_sent;
  int samples_checked;
  int reg_writes;
  int settings_used;
  int cycle_count;
  int in_gap_pct;
  int out_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Reference arithmetic: Q.15 values held in 24 bits, saturating
  // ---------------------------------------------------------------------------
  function automatic longint clip_q24(input longint v);
    if (v > 64'sd8388607) begin
      return 64'sd8388607;
    end else if (v < -64'sd8388608) begin
      return -64'sd8388608;
    end
    return v;
  endfunction

  // product with a Q15 gain, rounded half up
  function automatic longint q15_scale(input longint x, input longint g);
    return (x * g + 64'sd16384) >>> 15;
  endfunction

  // lengths: combs 0..3, allpass stages 4..5
  function automatic int line_len(input int idx);
    case (idx)
      0:       return (297 * RATE + 5000) / 10000;
      1:       return (371 * RATE + 5000) / 10000;
      2:       return (411 * RATE + 5000) / 10000;
      3:       return (437 * RATE + 5000) / 10000;
      4:       return (50 * RATE + 5000) / 10000;
      default: return (17 * RATE + 5000) / 10000;
    endcase
  endfunction

  // Advances the mirrored reverb by one sample and returns the mixed output.
  function automatic logic signed [15:0] predict_sample(input logic signed [15:0] s);
    longint wet, dry, decay, damp, x, pre, acc, rev, dl, y, mixed;
    int     plen, p, q, c;
    wet   = (shadow.wet_mix > srdc_pkg::UNITY) ? srdc_pkg::UNITY : shadow.wet_mix;
    dry   = srdc_pkg::UNITY - wet;
    decay = (shadow.decay_gain > srdc_pkg::DECAY_MAX) ? srdc_pkg::DECAY_MAX
                                                      : shadow.decay_gain;
    damp  = (shadow.damping > srdc_pkg::UNITY) ? srdc_pkg::UNITY : shadow.damping;
    x     = s;

    // pre-delay: zero length acts as one, lengths past the store clamp
    plen = shadow.predelay_len;
    if (plen < 1) plen = 1;
    if (plen > PRE_DEPTH) plen = PRE_DEPTH;
    p = (pre_pos >= plen) ? 0 : pre_pos;
    pre = pre_mem[p];
    pre_mem[p] = int'(x);
    pre_pos = (p + 1 >= plen) ? 0 : p + 1;

    // four damped combs in parallel
    acc = 0;
    for (c = 0; c < 4; c++) begin
      q  = (comb_pos[c] >= line_len(c)) ? 0 : comb_pos[c];
      dl = comb_mem[c][q];
      comb_lp[c]     = int'(clip_q24(comb_lp[c] + q15_scale(dl - comb_lp[c], damp)));
      comb_mem[c][q] = int'(clip_q24(pre + q15_scale(comb_lp[c], decay)));
      comb_pos[c]    = (q + 1 >= line_len(c)) ? 0 : q + 1;
      acc += dl;
    end
    rev = clip_q24((acc + 2) >>> 2);

    // two allpass stages, gain one half
    for (c = 0; c < 2; c++) begin
      q  = (ap_pos[c] >= line_len(4 + c)) ? 0 : ap_pos[c];
      dl = ap_mem[c][q];
      y  = clip_q24(dl - q15_scale(rev, 16384));
      ap_mem[c][q] = int'(clip_q24(rev + q15_scale(dl, 16384)));
      ap_pos[c]    = (q + 1 >= line_len(4 + c)) ? 0 : q + 1;
      rev = y;
    end

    mixed = (dry * x + wet * rev + 64'sd16384) >>> 15;
    if (mixed > 32767) mixed = 32767;
    if (mixed < -32768) mixed = -32768;
    return 16'(mixed);
  endfunction

  // ---------------------------------------------------------------------------
  // Shared helpers
  // ---------------------------------------------------------------------------
  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("ERROR @%0t: %s", $time, what);
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap_len();
    return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60);
  endfunction

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(9))
      0, 1:    return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      2, 3:    return 16'($urandom_range(511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // One input request. valid stays high on return so back-to-back requests
  // need no second assignment in the same step; drain() drops it.
  task automatic send_sample(input logic signed [15:0] s);
    int gap;
    gap = ($urandom_range(99) < in_gap_pct) ? pick_gap_len() : 0;
    if (gap > 0) begin
      in_if.valid     <= 1'b0;
      in_if.in_sample <= 16'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.in_sample <= s;
    do @(posedge clk_i); while (!in_if.ready);
    due_samples.push_back(predict_sample(s));
    samples_sent++;
  endtask

  task automatic play(input int n);
    repeat (n) send_sample(random_sample());
  endtask

  // wait for every predicted sample, then give the sequencer time to settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_read(input srdc_pkg::reg_e r, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write, mirror and read back. Bits above the field are sometimes junk.
  task automatic reg_write(input srdc_pkg::reg_e r, input logic [31:0] value);
    logic [31:0] want, word, got;
    int          width;
    case (r)
      srdc_pkg::REG_WET_MIX: width = 16;
      srdc_pkg::REG_DECAY:   width = 15;
      srdc_pkg::REG_DAMPING: width = 16;
      default:               width = 13;
    endcase
    want = value & ((32'd1 << width) - 32'd1);
    word = want;
    if ($urandom_range(3) == 0) word = word | ($urandom << width);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (r)
      srdc_pkg::REG_WET_MIX: shadow.wet_mix    = want[15:0];
      srdc_pkg::REG_DECAY:   shadow.decay_gain = want[14:0];
      srdc_pkg::REG_DAMPING: shadow.damping    = want[15:0];
      default: begin
        // any length write flushes the pre-delay
        shadow.predelay_len = want[12:0];
        foreach (pre_mem[i]) pre_mem[i] = 0;
        pre_pos = 0;
      end
    endcase
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    reg_read(r, got);
    if (got !== want)
      note_failure($sformatf("reg %s readback: expected %0h, got %0h", r.name(), want, got));
  endtask

  task automatic configure(input int wet, input int decay, input int damp, input int plen,
                           input bit set_plen);
    reg_write(srdc_pkg::REG_WET_MIX, wet);
    reg_write(srdc_pkg::REG_DECAY, decay);
    reg_write(srdc_pkg::REG_DAMPING, damp);
    if (set_plen) reg_write(srdc_pkg::REG_PREDELAY_LEN, plen);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and output back-pressure
  // ---------------------------------------------------------------------------
  initial begin : result_check
    logic signed [15:0] want;
    int                 stall;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (due_samples.size() == 0) begin
          note_failure($sformatf("unexpected result %0d", out_if.out_sample));
        end else begin
          want = due_samples.pop_front();
          samples_checked++;
          if (out_if.out_sample !== want)
            note_failure($sformatf("out_sample #%0d: expected %0d, got %0d",
                                   samples_checked, want, out_if.out_sample));
        end
      end
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(99) < out_stall_pct) begin
        stall = pick_gap_len() - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, due_samples.size());
    $display("schroeder_reverb_damped_comb regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_values();
    logic [31:0] got;
    reg_read(srdc_pkg::REG_WET_MIX, got);
    if (got !== 32'd16384) note_failure($sformatf("wet mix reset: got %0h", got));
    reg_read(srdc_pkg::REG_DECAY, got);
    if (got !== 32'd16384) note_failure($sformatf("decay gain reset: got %0h", got));
    reg_read(srdc_pkg::REG_DAMPING, got);
    if (got !== 32'd16384) note_failure($sformatf("damping reset: got %0h", got));
    reg_read(srdc_pkg::REG_PREDELAY_LEN, got);
    if (got !== 32'd1) note_failure($sformatf("predelay_len reset: got %0h", got));
  endtask

  // full-scale and bit-pattern samples, then gains at and beyond their limits
  task automatic test_directed_corners();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shFFFF);
    send_sample(16'sh0001);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    drain();
    configure(0, 16384, 16384, 1, 1'b0);          // dry only
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh1234);
    drain();
    configure(32768, 32112, 32768, 1, 1'b0);      // wet only, top decay
    play(3);
    drain();
    configure(65535, 32767, 65535, 0, 1'b1);      // over-range gains, zero length
    play(3);
    drain();
    configure(16384, 0, 0, 1, 1'b1);              // no feedback, frozen lowpass
    play(3);
    drain();
  endtask

  // pre-delay flush on rewrite, deepest and over-range lengths
  task automatic test_predelay_flush();
    configure(20000, 24000, 8000, 5, 1'b1);
    play(12);
    drain();
    reg_write(srdc_pkg::REG_PREDELAY_LEN, 5);     // same value still clears
    play(12);
    drain();
    configure(30000, 28000, 12000, PRE_DEPTH, 1'b1);
    play(30);
    drain();
    configure(30000, 28000, 12000, 8191, 1'b1);   // acts as the full depth
    play(20);
    drain();
  endtask

  // loud square bursts at maximum decay to push the mix into saturation
  task automatic test_saturation();
    int                 run;
    logic signed [15:0] level;
    configure(32768, 32112, 32768, 3, 1'b1);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    level = 16'sh7FFF;
    for (int n = 0; n < 300; n += run) begin
      run = $urandom_range(20, 120);
      if (n == 150) begin
        in_gap_pct    = 30;
        out_stall_pct = 30;
      end
      repeat (run) send_sample(level);
      level = (level == 16'sh7FFF) ? 16'sh8000 : 16'sh7FFF;
    end
    drain();
  endtask

  task automatic test_random_settings();
    int wet, decay, damp, plen;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          wet = 0; decay = 0; damp = 0; plen = 0;
        end
        1: begin
          wet = 65535; decay = 32767; damp = 65535; plen = 8191;
        end
        2: begin
          wet = 32768; decay = 32112; damp = 32768; plen = 1;
        end
        default: begin
          wet   = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(32768);
          decay = $urandom_range(32767);
          damp  = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(32768);
          plen  = ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(64);
        end
      endcase
      // one quiet phase with no idling at all, the rest vary
      in_gap_pct    = (ph == 3) ? 0 : $urandom_range(10, 60);
      out_stall_pct = (ph == 3) ? 0 : $urandom_range(10, 60);
      configure(wet, decay, damp, plen, ph < 3 || $urandom_range(1) == 1);
      play(150);
      drain();
    end
  endtask

  initial begin : main_seq
    fail_count      = 0;
    samples_sent    = 0;
    samples_checked = 0;
    reg_writes      = 0;
    settings_used   = 1;
    in_gap_pct      = 30;
    out_stall_pct   = 30;
    shadow.wet_mix      = 16'd16384;
    shadow.decay_gain   = 15'd16384;
    shadow.damping      = 16'd16384;
    shadow.predelay_len = 13'd1;
    shadow.pd_clear     = 1'b0;
    pre_pos = 0;
    comb_pos = '{default: 0};
    ap_pos   = '{default: 0};
    comb_lp  = '{default: 0};

    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.in_sample <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_directed_corners();
    test_predelay_flush();
    test_saturation();
    test_random_settings();

    $display("checked %0d of %0d samples over %0d gain/length settings, %0d register writes",
             samples_checked, samples_sent, settings_used, reg_writes);
    $display("%0d failures in %0d cycles", fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("schroeder_reverb_damped_comb regression: pass");
    end else begin
      $display("schroeder_reverb_damped_comb regression: fail");
    end
    $finish;
  end

endmodule
